// ===== rtl/mar_pkg.sv =====
// ----------------------------------------------------------------------------
// mar_pkg
// Shared types and constants for the moving average with ramp-up block.
// ----------------------------------------------------------------------------
package mar_pkg;

  // Width of the window size register and of the samples-used count.
  localparam int USED_W = 7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // write the incoming word into the ring
    logic setup;     // compute the count used and arm the ring walk
    logic sum_en;    // walk the ring and accumulate
    logic div_load;  // load the divider from the finished sum
    logic div_en;    // one quotient bit
    logic load_out;  // move the quotient into the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sum_done;
    logic div_done;
  } dp_sts_t;

endpackage

// ===== rtl/moving_average_rampup_top.sv =====
// ----------------------------------------------------------------------------
// moving_average_rampup_top
// Moving average with ramp-up over the most recent samples of a series.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_stall    in_sample, in_start_series
//   out      output     out_valid/out_stall  out_average, out_samples_used
//   cfg      input      cfg_valid/cfg_ready  cfg_data (window size)
//
// For each accepted word the ring is walked one entry a cycle through its
// single read port, then a restoring divider produces one quotient bit per
// cycle over the full sum width.
// Reset is synchronous, active low; it clears the fill count and pointer,
// and sets the window size to one. The ring needs no clearing pass.
// A new input word is taken while a finished result waits in the output
// register; a stalled result holds until taken.
// ----------------------------------------------------------------------------
module moving_average_rampup_top #(
  parameter int WINDOW_DEPTH = 64,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [SAMPLE_BITS-1:0]      in_sample,
  input  logic                        in_start_series,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [SAMPLE_BITS-1:0]      out_average,
  output logic [mar_pkg::USED_W-1:0]  out_samples_used,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mar_pkg::USED_W-1:0]  cfg_data
);
  import mar_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // The window register can be written on any cycle.
  assign cfg_ready = 1'b1;

  mar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mar_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample        (in_sample),
    .in_start_series  (in_start_series),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .out_average      (out_average),
    .out_samples_used (out_samples_used)
  );

endmodule

// ===== rtl/mar_ram.sv =====
// ----------------------------------------------------------------------------
// mar_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mar_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mar_ctrl.sv =====
// ----------------------------------------------------------------------------
// mar_ctrl
// Sequencing state machine: accept, ring walk, division, result hand-off.
// ----------------------------------------------------------------------------
module mar_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  mar_pkg::dp_sts_t   sts,
  output mar_pkg::ctl_cmd_t  cmd
);
  import mar_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The output register can take a new word when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (sts.sum_done) begin
          cmd.div_load = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          cmd.sum_en = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_en = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A result only appears after the division has finished.
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("output became valid outside the hand-off state");

  // A stalled result is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.load_out)
    else $error("result register overwritten while stalled");

endmodule

// ===== rtl/mar_dp.sv =====
// ----------------------------------------------------------------------------
// mar_dp
// Datapath: history ring, fill count, ring walk accumulator, restoring
// divider and output register.
// ----------------------------------------------------------------------------
module mar_dp #(
  parameter int WINDOW_DEPTH = 64,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mar_pkg::ctl_cmd_t           cmd,
  output mar_pkg::dp_sts_t            sts,
  input  logic [SAMPLE_BITS-1:0]      in_sample,
  input  logic                        in_start_series,
  input  logic                        cfg_we,
  input  logic [mar_pkg::USED_W-1:0]  cfg_data,
  output logic [SAMPLE_BITS-1:0]      out_average,
  output logic [mar_pkg::USED_W-1:0]  out_samples_used
);
  import mar_pkg::*;

  localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int WIDE_W = (CNT_W > USED_W) ? CNT_W : USED_W;
  localparam int SUM_W  = SAMPLE_BITS + USED_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FILL_MAX   = CNT_W'(WINDOW_DEPTH);
  localparam logic [WIDE_W-1:0] DEPTH_WIDE = WIDE_W'(WINDOW_DEPTH);

  // Configuration, ring bookkeeping and walk state.
  logic [USED_W-1:0]      win_r;
  logic [PTR_W-1:0]       ptr_r, ptr_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [USED_W-1:0]      used_r;
  logic [PTR_W-1:0]       rd_addr_r;
  logic [USED_W-1:0]      issue_cnt_r;
  logic                   acc_valid_r;
  logic signed [SUM_W-1:0] sum_r;

  // Divider state.
  logic                   neg_r;
  logic [SUM_W-1:0]       quo_r;
  logic [USED_W-1:0]      rem_r;
  logic [DCNT_W-1:0]      div_cnt_r;

  // Output register.
  logic [SAMPLE_BITS-1:0] avg_r;
  logic [USED_W-1:0]      used_out_r;

  logic                   rd_en;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [PTR_W-1:0]       rd_start;
  logic [PTR_W-1:0]       rd_addr_dec;
  logic [WIDE_W-1:0]      win_wide, w_eff, fill_wide, used_wide;
  logic [SUM_W-1:0]       sum_abs;
  logic [USED_W:0]        rem_sh;
  logic                   rem_ge;
  logic [USED_W:0]        rem_sub;
  logic [SUM_W-1:0]       quo_signed;

  mar_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (ptr_r),
    .wdata (in_sample),
    .re    (rd_en),
    .raddr (rd_addr_r),
    .rdata (rd_data)
  );

  // Accepted words advance the pointer; fill counts the series to depth.
  always_comb begin
    ptr_nxt  = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
    fill_nxt = in_start_series ? '0 : fill_r;
    if (fill_nxt != FILL_MAX) begin
      fill_nxt = fill_nxt + 1'b1;
    end
  end

  // Effective window, clamped to one and to the ring depth.
  always_comb begin
    win_wide  = WIDE_W'(win_r);
    fill_wide = WIDE_W'(fill_r);
    if (win_wide == '0) begin
      w_eff = WIDE_W'(1);
    end else if (win_wide > DEPTH_WIDE) begin
      w_eff = DEPTH_WIDE;
    end else begin
      w_eff = win_wide;
    end
    used_wide = (fill_wide < w_eff) ? fill_wide : w_eff;
  end

  // The newest sample sits one slot behind the write pointer.
  assign rd_start    = (ptr_r == '0) ? PTR_LAST : ptr_r - 1'b1;
  assign rd_addr_dec = (rd_addr_r == '0) ? PTR_LAST : rd_addr_r - 1'b1;
  assign rd_en       = cmd.sum_en && (issue_cnt_r != '0);

  // Divider: magnitude of the sum, one restoring step per cycle.
  assign sum_abs    = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign rem_sh     = {rem_r, quo_r[SUM_W-1]};
  assign rem_ge     = rem_sh >= {1'b0, used_r};
  assign rem_sub    = rem_sh - {1'b0, used_r};
  assign quo_signed = neg_r ? SUM_W'(-quo_r) : quo_r;

  assign sts.sum_done = (issue_cnt_r == '0) && !acc_valid_r;
  assign sts.div_done = (div_cnt_r == '0);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= USED_W'(1);
      ptr_r       <= '0;
      fill_r      <= '0;
      issue_cnt_r <= '0;
      acc_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        win_r <= cfg_data;
      end
      if (cmd.accept) begin
        ptr_r  <= ptr_nxt;
        fill_r <= fill_nxt;
      end
      if (cmd.setup) begin
        issue_cnt_r <= USED_W'(used_wide);
        acc_valid_r <= 1'b0;
      end else if (cmd.sum_en) begin
        acc_valid_r <= rd_en;
        if (rd_en) begin
          issue_cnt_r <= issue_cnt_r - 1'b1;
        end
      end
      if (cmd.div_load) begin
        div_cnt_r <= DCNT_W'(SUM_W);
      end else if (cmd.div_en && (div_cnt_r != '0)) begin
        div_cnt_r <= div_cnt_r - 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      used_r    <= USED_W'(used_wide);
      rd_addr_r <= rd_start;
      sum_r     <= '0;
    end else if (cmd.sum_en) begin
      if (rd_en) begin
        rd_addr_r <= rd_addr_dec;
      end
      if (acc_valid_r) begin
        sum_r <= sum_r + {{USED_W{rd_data[SAMPLE_BITS-1]}}, rd_data};
      end
    end
    if (cmd.div_load) begin
      neg_r <= sum_r[SUM_W-1];
      quo_r <= sum_abs;
      rem_r <= '0;
    end else if (cmd.div_en && (div_cnt_r != '0)) begin
      rem_r <= rem_ge ? rem_sub[USED_W-1:0] : rem_sh[USED_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], rem_ge};
    end
    if (cmd.load_out) begin
      avg_r      <= quo_signed[SAMPLE_BITS-1:0];
      used_out_r <= used_r;
    end
  end

  assign out_average      = avg_r;
  assign out_samples_used = used_out_r;

  // The fill count never passes the ring depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("fill count beyond ring depth");

  // The count used is at least one and never more than the series holds.
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.setup |=> (used_r != '0) && (WIDE_W'(used_r) <= WIDE_W'(fill_r)))
    else $error("samples used out of range");

  // The partial remainder stays below the divisor while dividing.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (div_cnt_r != '0) |-> (rem_r < used_r))
    else $error("divider remainder not below divisor");

endmodule
